FILE: sv/itfn_pkg.sv
// shared types and constants for the indexed triangle face normal block
package itfn_pkg;
    localparam int VERTEX_DEPTH = 1024;
    localparam int IDX_W = $clog2(VERTEX_DEPTH);
    localparam int CNT_W = IDX_W + 1;

    typedef enum logic [1:0] {
        CMD_APPEND   = 2'd0,
        CMD_TRIANGLE = 2'd1,
        CMD_CLEAR    = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_DEGENERATE = 2'd1,
        ST_UNWRITTEN  = 2'd2,
        ST_FULL       = 2'd3
    } status_t;

    // control from the sequencer to the datapath
    typedef struct packed {
        logic       sqrt_start;
        logic       div_start;
        logic [1:0] div_sel;
    } itfn_ctl_t;

    // status from the datapath back to the sequencer
    typedef struct packed {
        logic sqrt_done;
        logic div_done;
    } itfn_sts_t;
endpackage

FILE: sv/itfn_sqrt.sv
// iterative floor square root, one result bit per cycle
module itfn_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [69:0] radicand,
    output logic        done,
    output logic [35:0] root
);
    import itfn_pkg::*;

    logic [71:0] rem_reg, rem_next;
    logic [71:0] val_reg, val_next;
    logic [35:0] root_reg, root_next;
    logic [5:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [71:0] trial;
    logic [71:0] rem_sh;

    // restoring digit recurrence, two radicand bits per step
    always_comb begin
        rem_sh    = {rem_reg[69:0], val_reg[71:70]};
        trial     = {34'd0, root_reg, 2'b01};
        rem_next  = rem_reg;
        val_next  = val_reg;
        root_next = root_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            val_next  = {2'b00, radicand};
            root_next = '0;
            step_next = 6'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            val_next = {val_reg[69:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[34:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[34:0], 1'b0};
            end
            step_next = step_reg + 6'd1;
            if (step_reg == 6'd35) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg  <= rem_next;
        val_reg  <= val_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

FILE: sv/itfn_div.sv
// iterative signed divider for one normal component, truncating and clamped
module itfn_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [34:0] numer,
    input  logic [35:0]        denom,
    output logic               done,
    output logic signed [15:0] quot
);
    import itfn_pkg::*;

    // |n| * 32768 is below 2^50
    logic [49:0] num_reg, num_next;
    logic [50:0] rem_reg, rem_next;
    logic [49:0] q_reg, q_next;
    logic [35:0] den_reg;
    logic        neg_reg;
    logic [5:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [50:0] rem_sh;
    logic [34:0] mag_n;
    logic signed [15:0] q_sat;

    assign mag_n = numer[34] ? 35'(-numer) : numer;

    always_comb begin
        rem_sh    = {rem_reg[49:0], num_reg[49]};
        num_next  = num_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = {mag_n, 15'd0};
            rem_next  = '0;
            q_next    = '0;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[48:0], 1'b0};
            if (rem_sh >= {15'd0, den_reg}) begin
                rem_next = rem_sh - {15'd0, den_reg};
                q_next   = {q_reg[48:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                q_next   = {q_reg[48:0], 1'b0};
            end
            step_next = step_reg + 6'd1;
            if (step_reg == 6'd49) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // clamp magnitude then apply sign
    always_comb begin
        if (q_reg > 50'd32767) begin
            q_sat = 16'sd32767;
        end else begin
            q_sat = signed'(q_reg[15:0]);
        end
        quot = neg_reg ? -q_sat : q_sat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start) begin
            den_reg <= denom;
            neg_reg <= numer[34];
        end
    end

    assign done = done_reg;
endmodule

FILE: sv/indexed_triangle_face_normal.sv
// top level of the indexed triangle face normal block
//
//  channel | ports                         | direction
//  s_      | s_valid/s_ready + command...  | in, one command per transfer
//  m_      | m_valid/m_ready + normal...   | out, one result per command
//  cfg     | cfg_we/cfg_wdata              | in, scale register write
//
// append passes the append state, an unwritten index the first read; clear and unused go straight to output
// triangle: 3 memory reads, 6 multiplies on one multiplier, a square root and
// three divisions on one divider; a degenerate triangle skips the divisions
// every command then waits in the hold state while m_ready is held low
// s_ready is low while an item is in work or its result waits on m_ready
// synchronous active low reset empties the store; no clearing pass needed
module indexed_triangle_face_normal (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [15:0]                cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_command,
    input  logic signed [15:0]         s_coord_x,
    input  logic signed [15:0]         s_coord_y,
    input  logic signed [15:0]         s_coord_z,
    input  logic [itfn_pkg::IDX_W-1:0] s_index_a,
    input  logic [itfn_pkg::IDX_W-1:0] s_index_b,
    input  logic [itfn_pkg::IDX_W-1:0] s_index_c,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [15:0]         m_normal_x,
    output logic signed [15:0]         m_normal_y,
    output logic signed [15:0]         m_normal_z,
    output logic [1:0]                 m_status,
    output logic [itfn_pkg::IDX_W-1:0] m_slot
);
    import itfn_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_APP   = 13'b0000000000010,
        S_RDA   = 13'b0000000000100,
        S_RDB   = 13'b0000000001000,
        S_RDC   = 13'b0000000010000,
        S_EDGE  = 13'b0000000100000,
        S_MUL   = 13'b0000001000000,
        S_SQ    = 13'b0000010000000,
        S_SQRT  = 13'b0000100000000,
        S_CHK   = 13'b0001000000000,
        S_DIV   = 13'b0010000000000,
        S_OUT   = 13'b0100000000000,
        S_HOLD  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0]      scale_reg;
    logic [CNT_W-1:0] count_reg;
    logic [1:0]       cmd_reg;
    logic signed [15:0] cin_reg [3];
    logic [IDX_W-1:0] ia_reg, ib_reg, ic_reg;
    logic [1:0]       cnt_reg;      // coordinate / product / divide counter
    logic [2:0]       mcnt_reg;     // multiply step counter

    // vertex memory
    logic [47:0]      vmem [VERTEX_DEPTH];
    logic [47:0]      rd_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [47:0]      wr_data;

    logic signed [16:0] va [3];
    logic signed [16:0] e0 [3];
    logic signed [16:0] e1 [3];
    logic signed [34:0] n_reg [3];
    logic signed [33:0] prod_reg;
    logic [69:0]        sum_reg;
    logic signed [15:0] q_reg [3];

    logic signed [15:0] sc [3];
    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] mul_p;

    itfn_ctl_t ctl;
    itfn_sts_t sts;
    logic [35:0]        root;
    logic signed [15:0] dquot;
    logic signed [34:0] dnum;

    logic signed [15:0] ox_reg, oy_reg, oz_reg;
    logic [1:0]         ost_reg;
    logic [IDX_W-1:0]   oslot_reg;
    logic               mvalid_reg;

    // append scaling: floor shift by 12, saturate to Q8.8
    always_comb begin
        logic signed [32:0] p;
        logic signed [20:0] q;
        for (int i = 0; i < 3; i++) begin
            p = cin_reg[i] * $signed({1'b0, scale_reg});
            q = p[32:12];
            if (q > 21'sd32767) sc[i] = 16'sd32767;
            else if (q < -21'sd32768) sc[i] = -16'sd32768;
            else sc[i] = q[15:0];
        end
    end

    // shared multiplier operand select: six cross terms; the squares use their own
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (mcnt_reg)
            3'd0: begin mul_a = e0[1]; mul_b = e1[2]; end
            3'd1: begin mul_a = e0[2]; mul_b = e1[1]; end
            3'd2: begin mul_a = e0[2]; mul_b = e1[0]; end
            3'd3: begin mul_a = e0[0]; mul_b = e1[2]; end
            3'd4: begin mul_a = e0[0]; mul_b = e1[1]; end
            3'd5: begin mul_a = e0[1]; mul_b = e1[0]; end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // divider numerator: x on the first start, then y and z on restarts
    always_comb begin
        if (state_reg != S_DIV) dnum = n_reg[0];
        else if (cnt_reg == 2'd0) dnum = n_reg[1];
        else dnum = n_reg[2];
    end

    // squared length, one 35x35 product per cycle via magnitude
    logic [34:0] sq_in;
    logic [69:0] sq_p;
    always_comb begin
        case (cnt_reg)
            2'd0:    sq_in = n_reg[0][34] ? 35'(-n_reg[0]) : n_reg[0];
            2'd1:    sq_in = n_reg[1][34] ? 35'(-n_reg[1]) : n_reg[1];
            default: sq_in = n_reg[2][34] ? 35'(-n_reg[2]) : n_reg[2];
        endcase
        sq_p = sq_in * sq_in;
    end

    always_comb begin
        rd_addr = ia_reg;
        if (state_reg == S_RDB) rd_addr = ib_reg;
        else if (state_reg == S_RDC) rd_addr = ic_reg;
        wr_en   = (state_reg == S_APP) && (count_reg < CNT_W'(VERTEX_DEPTH));
        wr_data = {sc[2], sc[1], sc[0]};
    end

    // vertex memory ports, read data held once vertex c is in
    always_ff @(posedge aclk) begin
        if (wr_en) vmem[count_reg[IDX_W-1:0]] <= wr_data;
        if (state_reg == S_RDA || state_reg == S_RDB || state_reg == S_RDC)
            rd_reg <= vmem[rd_addr];
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        ctl.sqrt_start = (state_reg == S_SQ) && (cnt_reg == 2'd3);
        ctl.div_start  = (state_reg == S_CHK) && (root != '0);
        ctl.div_sel    = cnt_reg;
    end

    itfn_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctl.sqrt_start),
        .radicand (sum_reg),
        .done     (sts.sqrt_done),
        .root     (root)
    );

    itfn_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctl.div_start || (state_reg == S_DIV && sts.div_done
                                     && cnt_reg != 2'd2)),
        .numer    (dnum),
        .denom    (root),
        .done     (sts.div_done),
        .quot     (dquot)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_command == CMD_APPEND) state_next = S_APP;
                    else if (s_command == CMD_TRIANGLE) state_next = S_RDA;
                    else state_next = S_OUT;
                end
            end
            S_APP:  state_next = S_OUT;
            S_RDA: begin
                if (ia_reg >= count_reg || ib_reg >= count_reg
                    || ic_reg >= count_reg) state_next = S_OUT;
                else state_next = S_RDB;
            end
            S_RDB:  state_next = S_RDC;
            S_RDC:  state_next = S_EDGE;
            S_EDGE: state_next = S_MUL;
            S_MUL:  if (mcnt_reg == 3'd6) state_next = S_SQ;
            S_SQ:   if (cnt_reg == 2'd3) state_next = S_SQRT;
            S_SQRT: if (sts.sqrt_done) state_next = S_CHK;
            S_CHK:  state_next = (root == '0) ? S_OUT : S_DIV;
            S_DIV:  if (sts.div_done && cnt_reg == 2'd2) state_next = S_OUT;
            S_OUT:  state_next = S_HOLD;
            S_HOLD: if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // vertex a held, edges formed from the reads
    logic signed [15:0] vb [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            va[i] = 17'(signed'(cin_reg[i]));
            e0[i] = 17'(signed'(vb[i])) - va[i];
            e1[i] = 17'(signed'(rd_reg[16*i +: 16])) - va[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            scale_reg  <= 16'd4096;
            count_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) scale_reg <= cfg_wdata;
            if (state_reg == S_IDLE && s_valid && s_command == CMD_CLEAR)
                count_reg <= '0;
            if (wr_en) count_reg <= count_reg + 1'b1;
            if (state_reg == S_OUT) mvalid_reg <= 1'b1;
            else if (state_reg == S_HOLD && m_ready) mvalid_reg <= 1'b0;
        end

        // capture transfer
        if (state_reg == S_IDLE && s_valid) begin
            cmd_reg    <= s_command;
            cin_reg[0] <= s_coord_x;
            cin_reg[1] <= s_coord_y;
            cin_reg[2] <= s_coord_z;
            ia_reg     <= s_index_a;
            ib_reg     <= s_index_b;
            ic_reg     <= s_index_c;
            ox_reg     <= '0;
            oy_reg     <= '0;
            oz_reg     <= '0;
            ost_reg    <= ST_OK;
            oslot_reg  <= '0;
        end

        // operand stepping
        case (state_reg)
            S_APP: begin
                if (count_reg < CNT_W'(VERTEX_DEPTH))
                    oslot_reg <= count_reg[IDX_W-1:0];
                else
                    ost_reg <= ST_FULL;
            end
            S_RDA: begin
                if (ia_reg >= count_reg || ib_reg >= count_reg
                    || ic_reg >= count_reg) ost_reg <= ST_UNWRITTEN;
            end
            S_RDB: for (int i = 0; i < 3; i++) cin_reg[i] <= rd_reg[16*i +: 16];
            S_RDC: for (int i = 0; i < 3; i++) vb[i] <= rd_reg[16*i +: 16];
            S_EDGE: begin
                mcnt_reg <= 3'd0;
            end
            S_MUL: begin
                if (mcnt_reg != 3'd6) mcnt_reg <= mcnt_reg + 3'd1;
                if (mcnt_reg[0] == 1'b0) prod_reg <= mul_p;
                else n_reg[mcnt_reg[2:1]] <= 35'(prod_reg) - 35'(mul_p);
                cnt_reg <= 2'd0;
                sum_reg <= '0;
            end
            S_SQ: begin
                if (cnt_reg != 2'd3) begin
                    sum_reg <= sum_reg + sq_p;
                    cnt_reg <= cnt_reg + 2'd1;
                end
            end
            S_CHK: begin
                cnt_reg <= 2'd0;
                if (root == '0) ost_reg <= ST_DEGENERATE;
            end
            S_DIV: begin
                if (sts.div_done) begin
                    q_reg[cnt_reg] <= dquot;
                    if (cnt_reg != 2'd2) cnt_reg <= cnt_reg + 2'd1;
                end
            end
            S_OUT: begin
                if (ost_reg == ST_OK && cmd_reg == CMD_TRIANGLE) begin
                    ox_reg <= q_reg[0];
                    oy_reg <= q_reg[1];
                    oz_reg <= dquot;
                end
            end
            default: ;
        endcase
    end

    assign m_valid    = mvalid_reg;
    assign m_normal_x = ox_reg;
    assign m_normal_y = oy_reg;
    assign m_normal_z = oz_reg;
    assign m_status   = ost_reg;
    assign m_slot     = oslot_reg;

    // checks
    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("ready while result pending");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(VERTEX_DEPTH)) else $error("vertex count overflow");
    a_full_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_FULL) |-> (m_slot == '0))
        else $error("slot given on full store");
endmodule
